>>> hdl/stal_pkg.sv
// Shared types, constants and helpers for the session table with auth lockout.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package stal_pkg;

	localparam int SLOTS       = 4;
	localparam int SLOT_IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W       = $clog2(SLOTS + 1);

	localparam int IN_DATA_W   = 360;
	localparam int OUT_DATA_W  = 8;
	localparam int REQ_W       = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [31:0] TTL_RESET    = 32'd1800000;
	localparam logic [7:0]  FAILS_RESET  = 8'd5;
	localparam logic [31:0] LOCK_RESET   = 32'd60000;
	localparam logic [63:0] CODE_RESET   = 64'h2D2D_2D2D_2D2D_2D2D;
	localparam logic [31:0] OLDEST_START = 32'hFFFF_FFFF;

	typedef enum logic [REQ_W-1:0] {
		REQ_CHECK   = 2'd0,
		REQ_AUTH    = 2'd1,
		REQ_LOGOUT  = 2'd2,
		REQ_SETCODE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STS_AUTHED     = 3'd0,
		STS_NOT_AUTHED = 3'd1,
		STS_LOCKED     = 3'd2,
		STS_BAD_CODE   = 3'd3,
		STS_GRANTED    = 3'd4,
		STS_DROPPED    = 3'd5,
		STS_CODE_SET   = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TTL       = 2'd0,
		CFG_MAX_FAILS = 2'd1,
		CFG_LOCK_MS   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] ttl;
		logic [7:0]  fail_cap;
		logic [31:0] lock_ms;
	} cfg_regs_t;

	// Input word layout, lowest field last
	typedef struct packed {
		logic [6:0]  pad;
		logic [63:0] new_token_lo;
		logic [63:0] new_token_hi;
		logic        code_len_ok;
		logic [63:0] code;
		logic [63:0] token_lo;
		logic [63:0] token_hi;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [2:0] pad;
		logic [1:0] slot;
		status_t    status;
	} out_word_t;

	typedef struct packed {
		req_t        req;
		logic [31:0] now_ms;
		logic [63:0] token_hi;
		logic [63:0] token_lo;
		logic [63:0] code;
		logic        code_len_ok;
		logic [63:0] new_token_hi;
		logic [63:0] new_token_lo;
	} item_t;

	typedef struct packed {
		logic [63:0] token_hi;
		logic [63:0] token_lo;
		logic [31:0] seen_ms;
	} slot_entry_t;

	typedef struct packed {
		logic                  rd_en;
		logic                  wr_en;
		logic                  clr_en;
		logic [SLOT_IDX_W-1:0] addr;
		slot_entry_t           wdata;
	} mem_cmd_t;

	typedef struct packed {
		status_t    status;
		logic [1:0] slot;
	} result_t;

	// Slot number as reported on the result word: low two bits of the index
	function automatic logic [1:0] slot_code(input logic [SLOT_IDX_W-1:0] idx);
		logic [SLOT_IDX_W+1:0] wide;
		wide = {2'b00, idx};
		return wide[1:0];
	endfunction

endpackage

>>> hdl/stal_cfg_regs.sv
// Configuration register file: TTL, failure limit and lockout length.
// Depends on stal_pkg.
`timescale 1ns / 1ps

module stal_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [stal_pkg::CFG_IDX_W-1:0] index,
	input  logic [stal_pkg::CFG_DATA_W-1:0] wdata,
	output stal_pkg::cfg_regs_t            regs
);
	import stal_pkg::*;

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.ttl      <= TTL_RESET;
			regs_q.fail_cap <= FAILS_RESET;
			regs_q.lock_ms  <= LOCK_RESET;
		end else if (we) begin
			unique case (cfg_idx_t'(index))
				CFG_TTL:       regs_q.ttl      <= wdata;
				CFG_MAX_FAILS: regs_q.fail_cap <= wdata[7:0];
				CFG_LOCK_MS:   regs_q.lock_ms  <= wdata;
				default:       ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

>>> hdl/stal_slot_mem.sv
// Session slot store: token and last-seen memory with registered read, plus used flags.
// Depends on stal_pkg.
`timescale 1ns / 1ps

module stal_slot_mem (
	input  logic                   clk,
	input  logic                   arst_n,
	input  stal_pkg::mem_cmd_t     cmd,
	output stal_pkg::slot_entry_t  rdata,
	output logic [stal_pkg::SLOTS-1:0] used
);
	import stal_pkg::*;

	slot_entry_t       mem [SLOTS];
	slot_entry_t       rdata_q;
	logic [SLOTS-1:0]  used_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[cmd.addr] <= cmd.wdata;
		if (cmd.rd_en)
			rdata_q <= mem[cmd.addr];
	end

	// A write always marks the slot live; a clear drops it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.wr_en) begin
			used_q[cmd.addr] <= 1'b1;
		end else if (cmd.clr_en) begin
			used_q[cmd.addr] <= 1'b0;
		end
	end

	assign rdata = rdata_q;
	assign used  = used_q;

endmodule

>>> hdl/stal_engine.sv
// Request sequencer: lockout and code check, slot scan over the slot store.
// Depends on stal_pkg; drives stal_slot_mem through a command struct.
`timescale 1ns / 1ps

module stal_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  stal_pkg::item_t             in_item,
	input  stal_pkg::cfg_regs_t         cfg,
	output stal_pkg::mem_cmd_t          mem_cmd,
	input  stal_pkg::slot_entry_t       mem_rdata,
	input  logic [stal_pkg::SLOTS-1:0]  used,
	output logic                        res_valid,
	input  logic                        res_ready,
	output stal_pkg::result_t           res
);
	import stal_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_READ   = 6'b000100,
		S_EVAL   = 6'b001000,
		S_WRITE  = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      idx_q;
	logic [7:0]            fail_q;
	logic [31:0]           lock_until_q;
	logic [63:0]           dev_code_q;
	item_t                 item_q;
	logic [SLOT_IDX_W-1:0] pick_q;
	logic [31:0]           oldest_q;
	result_t               res_q;

	logic [SLOT_IDX_W-1:0] idx;
	logic                  last;
	logic                  used_cur;
	logic [31:0]           age;
	logic                  expired;
	logic                  match;
	logic [31:0]           lock_diff;
	logic                  lock_pend;
	logic                  code_ok;
	logic [7:0]            fail_inc;
	logic                  trip;
	logic                  older;
	logic                  hit;

	assign idx       = idx_q[SLOT_IDX_W-1:0];
	assign last      = (idx_q == CNT_W'(SLOTS - 1));
	assign used_cur  = used[idx];
	assign age       = item_q.now_ms - mem_rdata.seen_ms;
	assign expired   = (age > cfg.ttl);
	assign match     = (mem_rdata.token_hi == item_q.token_hi) &&
	                   (mem_rdata.token_lo == item_q.token_lo);
	assign lock_diff = item_q.now_ms - lock_until_q;
	assign lock_pend = (lock_until_q != '0) && lock_diff[31];
	assign code_ok   = item_q.code_len_ok && (item_q.code == dev_code_q);
	assign fail_inc  = fail_q + 8'd1;
	assign trip      = (fail_inc >= cfg.fail_cap);
	assign older     = (mem_rdata.seen_ms < oldest_q);
	assign hit       = used_cur && !expired && match;

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FINISH);
	assign res       = res_q;

	// Slot store commands
	always_comb begin
		mem_cmd       = '0;
		mem_cmd.addr  = idx;
		mem_cmd.wdata = '{token_hi: item_q.token_hi, token_lo: item_q.token_lo,
		                  seen_ms: item_q.now_ms};
		unique case (state_q)
			S_READ: mem_cmd.rd_en = 1'b1;
			S_EVAL: begin
				if (item_q.req == REQ_CHECK) begin
					// refresh on a live match, drop a stale slot
					mem_cmd.wr_en  = hit;
					mem_cmd.clr_en = used_cur && expired;
				end else if (item_q.req == REQ_LOGOUT) begin
					mem_cmd.clr_en = used_cur && match;
				end
			end
			S_WRITE: begin
				mem_cmd.wr_en = 1'b1;
				mem_cmd.addr  = pick_q;
				mem_cmd.wdata = '{token_hi: item_q.new_token_hi,
				                  token_lo: item_q.new_token_lo,
				                  seen_ms: item_q.now_ms};
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			fail_q       <= '0;
			lock_until_q <= '0;
			dev_code_q   <= CODE_RESET;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					idx_q <= '0;
					unique case (item_q.req)
						REQ_CHECK, REQ_LOGOUT: state_q <= S_READ;
						REQ_AUTH: begin
							if (lock_pend) begin
								state_q <= S_FINISH;
							end else if (!code_ok) begin
								if (trip) begin
									lock_until_q <= item_q.now_ms + cfg.lock_ms;
									fail_q       <= '0;
								end else begin
									lock_until_q <= '0;
									fail_q       <= fail_inc;
								end
								state_q <= S_FINISH;
							end else begin
								lock_until_q <= '0;
								fail_q       <= '0;
								state_q      <= S_READ;
							end
						end
						REQ_SETCODE: begin
							dev_code_q <= item_q.code;
							state_q    <= S_FINISH;
						end
					endcase
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: begin
					idx_q <= idx_q + CNT_W'(1);
					unique case (item_q.req)
						REQ_CHECK:   state_q <= (hit || last) ? S_FINISH : S_READ;
						REQ_LOGOUT:  state_q <= last ? S_FINISH : S_READ;
						REQ_AUTH:    state_q <= (!used_cur || last) ? S_WRITE : S_READ;
						REQ_SETCODE: state_q <= S_FINISH;
					endcase
				end
				S_WRITE: state_q <= S_FINISH;
				S_FINISH: begin
					if (res_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item, scan and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid)
					item_q <= in_item;
			end
			S_DECIDE: begin
				pick_q     <= '0;
				oldest_q   <= OLDEST_START;
				res_q.slot <= 2'd0;
				unique case (item_q.req)
					REQ_AUTH:    res_q.status <= lock_pend ? STS_LOCKED : STS_BAD_CODE;
					REQ_SETCODE: res_q.status <= STS_CODE_SET;
					REQ_LOGOUT:  res_q.status <= STS_DROPPED;
					REQ_CHECK:   res_q.status <= STS_NOT_AUTHED;
				endcase
			end
			S_EVAL: begin
				if (item_q.req == REQ_CHECK && hit) begin
					res_q.status <= STS_AUTHED;
					res_q.slot   <= slot_code(idx);
				end
				if (item_q.req == REQ_AUTH) begin
					if (!used_cur) begin
						pick_q <= idx;
					end else if (older) begin
						pick_q   <= idx;
						oldest_q <= mem_rdata.seen_ms;
					end
				end
			end
			S_WRITE: begin
				res_q.status <= STS_GRANTED;
				res_q.slot   <= slot_code(pick_q);
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/session_table_with_auth_lockout_core.sv
// Top level of the session table with auth lockout: stream ports and result register.
// Depends on stal_pkg, stal_cfg_regs, stal_slot_mem and stal_engine.
`timescale 1ns / 1ps

// Session table with authentication lockout. Each input word is one request
// (check, auth attempt, logout, set device code) and yields exactly one result
// word carrying a status and a slot number. Requests are handled one at a time:
// set-code and a refused or failed auth attempt finish without a slot scan; a
// check or logout scans the slots, and a granted auth scans them and then
// writes the picked slot. The scan is bound by the single port of the slot
// memory: every slot visited takes a read state and an evaluate state. A
// result waits in an output register, so the next word is taken as soon as
// the sequencer is back to idle even if the sink has not yet picked up the
// previous result. Configuration writes take effect at the next edge and
// belong in idle time only.
module session_table_with_auth_lockout_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// Request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata, low bit up: now_ms[32], token_hi[64], token_lo[64], code[64],
	// code_len_ok[1], new_token_hi[64], new_token_lo[64], zero fill[7]
	input  logic [stal_pkg::IN_DATA_W-1:0]  s_tdata,
	// s_tuser: req_type[2]
	input  logic [stal_pkg::REQ_W-1:0]      s_tuser,
	// Result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata, low bit up: status[3], slot[2], zero fill[3]
	output logic [stal_pkg::OUT_DATA_W-1:0] m_tdata,
	// Configuration writes
	input  logic                            cfg_we,
	input  logic [stal_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stal_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import stal_pkg::*;

	cfg_regs_t   cfg;
	in_word_t    in_word;
	item_t       item;
	mem_cmd_t    mem_cmd;
	slot_entry_t mem_rdata;
	logic [SLOTS-1:0] used;
	logic        res_valid;
	logic        res_ready;
	result_t     res;
	logic        m_tvalid_q;
	out_word_t   m_word_q;

	// Unpack the request word
	assign in_word           = in_word_t'(s_tdata);
	assign item.req          = req_t'(s_tuser);
	assign item.now_ms       = in_word.now_ms;
	assign item.token_hi     = in_word.token_hi;
	assign item.token_lo     = in_word.token_lo;
	assign item.code         = in_word.code;
	assign item.code_len_ok  = in_word.code_len_ok;
	assign item.new_token_hi = in_word.new_token_hi;
	assign item.new_token_lo = in_word.new_token_lo;

	stal_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.regs   (cfg)
	);

	stal_slot_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mem_cmd),
		.rdata  (mem_rdata),
		.used   (used)
	);

	// The sequencer finishes one request, including its slot write-back, before
	// it takes the next, so memory accesses to one entry never overlap.
	stal_engine u_eng (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.cfg       (cfg),
		.mem_cmd   (mem_cmd),
		.mem_rdata (mem_rdata),
		.used      (used),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Load the output register when it is empty or being drained this cycle
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	// Hold the word while the sink stalls
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_word_q.pad    <= '0;
			m_word_q.slot   <= res.slot;
			m_word_q.status <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_word_q;

endmodule

>>> hdl/stal_checker.sv
// Port-level checks for the session table core, attached by bind.
// Depends on stal_pkg and session_table_with_auth_lockout_core.
`timescale 1ns / 1ps

module stal_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [stal_pkg::OUT_DATA_W-1:0] m_tdata
);
	import stal_pkg::*;

	out_word_t ow;
	assign ow = out_word_t'(m_tdata);

	// One request in flight: the input closes right after a word is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a request is in flight");

	// A result only appears at the end of a request
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result word appeared without a request being finished");

	// Only authed and granted results name a slot
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ow.status != STS_AUTHED && ow.status != STS_GRANTED
		|-> ow.slot == 2'd0)
		else $error("nonzero slot on a result without a session");

	// Stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

endmodule

bind session_table_with_auth_lockout_core stal_checker u_stal_checker (.*);
